/* hdl/sactr_pkg.sv */
// ----------------------------------------------------------------------------
// Set-associative tag and replacement package
// Shared constants, register indexes, policy codes and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package sactr_pkg;

  // Default geometry
  localparam int WAYS_DEF        = 8;
  localparam int BLOCK_BYTES_DEF = 8;
  localparam int CACHE_BYTES_DEF = 128 * 1024;
  localparam int ADDR_BITS_DEF   = 64;

  // Queue depths between the parts
  localparam int REQ_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Fixed field widths
  localparam int CNT_W       = 32;
  localparam int WAY_OUT_W   = 3;
  localparam int RAND_W      = 3;
  localparam int CFG_DATA_W  = 2;
  localparam int CFG_INDEX_W = 1;

  // Replacement policy codes
  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_TREE = 2'd1;
  localparam logic [1:0] POL_RAND = 2'd2;
  localparam logic [1:0] POL_LFU  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_POLICY = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALLOC  = 1'd1;

  // One result word
  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 allocated;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
  } res_t;

endpackage

`default_nettype wire

/* hdl/sactr_front.sv */
// ----------------------------------------------------------------------------
// Access front end
// Accepts accesses, splits the address into set and tag, decides whether a
// miss may fill, and holds the requests in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sactr_front #(
  parameter int WAYS        = sactr_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES = sactr_pkg::BLOCK_BYTES_DEF,
  parameter int CACHE_BYTES = sactr_pkg::CACHE_BYTES_DEF,
  parameter int ADDR_BITS   = sactr_pkg::ADDR_BITS_DEF,
  localparam int LG_WAYS    = $clog2(WAYS),
  localparam int LG_BLOCK   = $clog2(BLOCK_BYTES),
  localparam int LG_CACHE   = $clog2(CACHE_BYTES),
  localparam int SET_LG     = LG_CACHE - LG_WAYS - LG_BLOCK,
  localparam int SETS       = 2 ** SET_LG,
  localparam int SB         = (SET_LG < 1) ? 1 : SET_LG,
  localparam int TAG_LSB    = LG_CACHE - LG_WAYS,
  localparam int TAG_BITS   = ADDR_BITS - TAG_LSB
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          hold,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [ADDR_BITS-1:0]          addr,
  input  wire logic                          is_write,
  input  wire logic [sactr_pkg::RAND_W-1:0]  rand_way,
  input  wire logic                          alloc_on_write,
  input  wire logic                          deq,
  output logic                               q_valid,
  output logic [SB-1:0]                      q_set,
  output logic [TAG_BITS-1:0]                q_tag,
  output logic                               q_alloc,
  output logic [sactr_pkg::RAND_W-1:0]       q_rand
);

  localparam int PTR_W = (sactr_pkg::REQ_DEPTH > 1) ? $clog2(sactr_pkg::REQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(sactr_pkg::REQ_DEPTH + 1);

  logic [SB-1:0]                    set_q   [sactr_pkg::REQ_DEPTH];
  logic [TAG_BITS-1:0]              tag_q   [sactr_pkg::REQ_DEPTH];
  logic                             alloc_q [sactr_pkg::REQ_DEPTH];
  logic [sactr_pkg::RAND_W-1:0]     rand_q  [sactr_pkg::REQ_DEPTH];
  logic [PTR_W-1:0]                 head, tail;
  logic [CNT_W-1:0]                 count;
  logic                             enq;
  logic [ADDR_BITS-1:0]             set_full;

  // Classify the incoming word
  assign set_full = (addr >> LG_BLOCK) & ADDR_BITS'(SETS - 1);
  assign full     = hold || (count == CNT_W'(sactr_pkg::REQ_DEPTH));
  assign enq      = push && !full;
  assign q_valid  = (count != '0);
  assign q_set    = set_q[head];
  assign q_tag    = tag_q[head];
  assign q_alloc  = alloc_q[head];
  assign q_rand   = rand_q[head];

  // Store the request payload
  always_ff @(posedge clk) begin
    if (enq) begin
      set_q[tail]   <= set_full[SB-1:0];
      tag_q[tail]   <= addr[ADDR_BITS-1:TAG_LSB];
      alloc_q[tail] <= !is_write || alloc_on_write;
      rand_q[tail]  <= rand_way;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        tail <= (tail == PTR_W'(sactr_pkg::REQ_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (deq) begin
        head <= (head == PTR_W'(sactr_pkg::REQ_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/sactr_back.sv */
// ----------------------------------------------------------------------------
// Lookup and replacement back end
// Reads a set's tags, valid bits and policy word, resolves hit or victim,
// writes the set back and counts hits and misses. Clears the set rows after
// reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sactr_back #(
  parameter int WAYS        = sactr_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES = sactr_pkg::BLOCK_BYTES_DEF,
  parameter int CACHE_BYTES = sactr_pkg::CACHE_BYTES_DEF,
  parameter int ADDR_BITS   = sactr_pkg::ADDR_BITS_DEF,
  localparam int LG_WAYS    = $clog2(WAYS),
  localparam int LG_BLOCK   = $clog2(BLOCK_BYTES),
  localparam int LG_CACHE   = $clog2(CACHE_BYTES),
  localparam int SET_LG     = LG_CACHE - LG_WAYS - LG_BLOCK,
  localparam int SETS       = 2 ** SET_LG,
  localparam int SB         = (SET_LG < 1) ? 1 : SET_LG,
  localparam int TAG_LSB    = LG_CACHE - LG_WAYS,
  localparam int TAG_BITS   = ADDR_BITS - TAG_LSB
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  input  wire logic [SB-1:0]                req_set,
  input  wire logic [TAG_BITS-1:0]          req_tag,
  input  wire logic                         req_alloc,
  input  wire logic [sactr_pkg::RAND_W-1:0] req_rand,
  input  wire logic [1:0]                   policy,
  input  wire logic                         res_space,
  output logic                              req_deq,
  output logic                              clearing,
  output logic                              res_push,
  output sactr_pkg::res_t                   res
);

  localparam int LGW = (LG_WAYS < 1) ? 1 : LG_WAYS;
  localparam int PW  = WAYS * LGW;
  localparam logic [LGW-1:0] FMASK = LGW'((1 << LG_WAYS) - 1);
  localparam logic [LGW-1:0] WMASK = LGW'(WAYS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;

  // Set rows
  logic [WAYS-1:0][TAG_BITS-1:0] tag_mem   [SETS];
  logic [WAYS-1:0]               valid_mem [SETS];
  logic [PW-1:0]                 pol_mem   [SETS];

  logic [WAYS-1:0][TAG_BITS-1:0] tag_rd, tag_wr;
  logic [WAYS-1:0]               valid_rd, valid_wr;
  logic [PW-1:0]                 pol_rd, pol_wr, pol_wdata;
  logic                          row_we, tag_we;
  logic [SB-1:0]                 wr_set;

  logic [SB-1:0]                 clr_idx;
  logic [SB-1:0]                 cur_set;
  logic [TAG_BITS-1:0]           cur_tag;
  logic                          cur_alloc;
  logic [sactr_pkg::RAND_W-1:0]  cur_rand;

  logic [sactr_pkg::CNT_W-1:0]   hit_count, miss_count;
  logic [sactr_pkg::CNT_W-1:0]   hit_count_next, miss_count_next;

  logic [LGW-1:0] fld [WAYS];
  logic [LGW-1:0] nf  [WAYS];
  logic           hit_any, free_any, alloc, fields_upd, tree_upd;
  logic [LGW-1:0] hit_way, spare_way, mx_way, mn_way, tv_way, rv_way, way;
  logic [LGW-1:0] mx, mn;
  logic [LGW:0]   nv, sum;
  logic [LGW+sactr_pkg::RAND_W-1:0] rand_ext;
  logic [LGW+sactr_pkg::WAY_OUT_W-1:0] way_ext;
  int             node;

  // Read the set row every cycle
  always_ff @(posedge clk) begin
    tag_rd   <= tag_mem[req_set];
    valid_rd <= valid_mem[req_set];
    pol_rd   <= pol_mem[req_set];
  end

  // Write the set row back
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_set] <= tag_wr;
    end
    if (row_we) begin
      valid_mem[wr_set] <= valid_wr;
      pol_mem[wr_set]   <= pol_wdata;
    end
  end

  // Split the policy word into per-way fields
  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      fld[j] = pol_rd[j*LGW +: LGW] & FMASK;
    end
  end

  // Resolve hit, victim and the new policy word
  always_comb begin
    hit_any   = 1'b0;
    hit_way   = '0;
    free_any  = 1'b0;
    spare_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid_rd[i] && (tag_rd[i] == cur_tag)) begin
        hit_any = 1'b1;
        hit_way = LGW'(i);
      end
      if (!valid_rd[i]) begin
        free_any  = 1'b1;
        spare_way = LGW'(i);
      end
    end

    // Largest and smallest field, lowest way on a tie
    mx     = fld[0];
    mx_way = '0;
    mn     = fld[0];
    mn_way = '0;
    for (int j = 1; j < WAYS; j++) begin
      if (fld[j] > mx) begin
        mx     = fld[j];
        mx_way = LGW'(j);
      end
      if (fld[j] < mn) begin
        mn     = fld[j];
        mn_way = LGW'(j);
      end
    end

    // Walk the pseudo-LRU tree to its victim leaf
    node = 0;
    for (int j = 0; j < LG_WAYS; j++) begin
      node = node * 2 + 1 + int'(pol_rd[node]);
    end
    tv_way = LGW'(node - (WAYS - 1));

    rand_ext = (LGW + sactr_pkg::RAND_W)'(cur_rand);
    rv_way   = rand_ext[LGW-1:0] & WMASK;

    way        = '0;
    alloc      = 1'b0;
    fields_upd = 1'b0;
    tree_upd   = 1'b0;
    nv         = '0;
    sum        = '0;
    nf         = fld;

    if (hit_any) begin
      way = hit_way;
      unique case (policy)
        sactr_pkg::POL_LRU: begin
          fields_upd = 1'b1;
          for (int j = 0; j < WAYS; j++) begin
            if (fld[j] < fld[hit_way]) begin
              nf[j] = (fld[j] + 1'b1) & FMASK;
            end else if (fld[j] == fld[hit_way]) begin
              nf[j] = '0;
            end
          end
        end
        sactr_pkg::POL_TREE: begin
          tree_upd = 1'b1;
        end
        sactr_pkg::POL_RAND: begin
          fields_upd = 1'b0;
        end
        sactr_pkg::POL_LFU: begin
          fields_upd = 1'b1;
          nv = {1'b0, fld[hit_way]} + 1'b1;
          if (nv == (LGW + 1)'(WAYS)) begin
            // Age the whole set: halve every count
            for (int j = 0; j < WAYS; j++) begin
              sum   = {1'b0, fld[j]} + ((LGW'(j) == hit_way) ? 1'b1 : 1'b0);
              nf[j] = sum[LGW:1] & FMASK;
            end
          end else begin
            nf[hit_way] = nv[LGW-1:0] & FMASK;
          end
        end
      endcase
    end else if (cur_alloc) begin
      alloc = 1'b1;
      unique case (policy)
        sactr_pkg::POL_LRU: begin
          fields_upd = 1'b1;
          way = free_any ? spare_way : mx_way;
          for (int j = 0; j < WAYS; j++) begin
            nf[j] = (LGW'(j) == way) ? '0 : ((fld[j] + 1'b1) & FMASK);
          end
        end
        sactr_pkg::POL_TREE: begin
          tree_upd = 1'b1;
          way = free_any ? spare_way : tv_way;
        end
        sactr_pkg::POL_RAND: begin
          way = free_any ? spare_way : rv_way;
        end
        sactr_pkg::POL_LFU: begin
          fields_upd = 1'b1;
          way = mn_way;
          nf[mn_way] = LGW'(1) & FMASK;
        end
      endcase
      way = way & WMASK;
    end

    // Assemble the policy word
    pol_wr = pol_rd;
    if (fields_upd) begin
      for (int j = 0; j < WAYS; j++) begin
        pol_wr[j*LGW +: LGW] = nf[j];
      end
    end
    if (tree_upd) begin
      node = 0;
      for (int j = LG_WAYS - 1; j >= 0; j--) begin
        pol_wr[node] = !way[j];
        node = node * 2 + 1 + int'(way[j]);
      end
    end
  end

  // Row write data and enables
  always_comb begin
    valid_wr = valid_rd;
    tag_wr   = tag_rd;
    row_we   = 1'b0;
    tag_we   = 1'b0;
    wr_set   = cur_set;
    if (state == ST_CLEAR) begin
      valid_wr = '0;
      row_we   = 1'b1;
      wr_set   = clr_idx;
    end else if (state == ST_EXEC) begin
      row_we = 1'b1;
      if (alloc) begin
        valid_wr[way] = 1'b1;
        tag_wr[way]   = cur_tag;
        tag_we        = 1'b1;
      end
    end
  end

  // Zero the policy word during the clearing pass
  assign pol_wdata = (state == ST_CLEAR) ? '0 : pol_wr;

  // Counters
  always_comb begin
    hit_count_next  = hit_count;
    miss_count_next = miss_count;
    if (hit_any) begin
      hit_count_next = hit_count + 1'b1;
    end else begin
      miss_count_next = miss_count + 1'b1;
    end
  end

  // Sequence: clear, wait for a request, execute
  assign req_deq  = (state == ST_IDLE) && req_valid && res_space;
  assign clearing = (state == ST_CLEAR);
  assign res_push = (state == ST_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == SB'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_deq) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      hit_count  <= '0;
      miss_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == ST_EXEC) begin
        hit_count  <= hit_count_next;
        miss_count <= miss_count_next;
      end
    end
  end

  // Hold the request being worked on
  always_ff @(posedge clk) begin
    if (req_deq) begin
      cur_set   <= req_set;
      cur_tag   <= req_tag;
      cur_alloc <= req_alloc;
      cur_rand  <= req_rand;
    end
  end

  // Result word
  always_comb begin
    way_ext        = (LGW + sactr_pkg::WAY_OUT_W)'(way);
    res.hit        = hit_any;
    res.way_used   = way_ext[sactr_pkg::WAY_OUT_W-1:0];
    res.allocated  = alloc;
    res.hit_total  = hit_count_next;
    res.miss_total = miss_count_next;
  end

endmodule

`default_nettype wire

/* hdl/sactr_res_fifo.sv */
// ----------------------------------------------------------------------------
// Result queue
// Holds finished result words until the consumer pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module sactr_res_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sactr_pkg::res_t din,
  input  wire logic            pop,
  output sactr_pkg::res_t      dout,
  output logic                 empty,
  output logic                 space
);

  localparam int PTR_W = (sactr_pkg::RES_DEPTH > 1) ? $clog2(sactr_pkg::RES_DEPTH) : 1;
  localparam int CNT_W = $clog2(sactr_pkg::RES_DEPTH + 1);

  sactr_pkg::res_t  mem [sactr_pkg::RES_DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign empty  = (count == '0);
  assign space  = (count != CNT_W'(sactr_pkg::RES_DEPTH));
  assign do_pop = pop && !empty;
  assign dout   = mem[head];

  // Store words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= din;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_W'(sactr_pkg::RES_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == PTR_W'(sactr_pkg::RES_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/set_assoc_cache_tag_replace_unit.sv */
// ----------------------------------------------------------------------------
// Set-associative tag store with selectable replacement
// Looks up each access, reports hit or fill, keeps hit and miss totals.
// ----------------------------------------------------------------------------
// In the back end an access first reads the set's tags, valid bits and
// policy word from the set memories, then resolves hit or victim and
// writes the row back through the single write port before the next access
// is taken. Accesses queue in front (two deep) and results queue behind
// (two deep), so push and pop stall independently. After reset the back
// end clears one set row per cycle, SETS rows in all (2048 at the default
// geometry), with full held high; configuration writes are taken during
// that pass. Policy is 0 LRU, 1 tree pseudo-LRU, 2 random (victim from
// rand_way), 3 LFU; changing it does not clear the per-set policy words.
`default_nettype none

module set_assoc_cache_tag_replace_unit #(
  parameter int WAYS        = sactr_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES = sactr_pkg::BLOCK_BYTES_DEF,
  parameter int CACHE_BYTES = sactr_pkg::CACHE_BYTES_DEF,
  parameter int ADDR_BITS   = sactr_pkg::ADDR_BITS_DEF,
  localparam int LG_WAYS    = $clog2(WAYS),
  localparam int LG_BLOCK   = $clog2(BLOCK_BYTES),
  localparam int LG_CACHE   = $clog2(CACHE_BYTES),
  localparam int SET_LG     = LG_CACHE - LG_WAYS - LG_BLOCK,
  localparam int SB         = (SET_LG < 1) ? 1 : SET_LG,
  localparam int TAG_BITS   = ADDR_BITS - (LG_CACHE - LG_WAYS)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [ADDR_BITS-1:0]              addr,
  input  wire logic                              is_write,
  input  wire logic [sactr_pkg::RAND_W-1:0]      rand_way,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   hit,
  output logic [sactr_pkg::WAY_OUT_W-1:0]        way_used,
  output logic                                   allocated,
  output logic [sactr_pkg::CNT_W-1:0]            hit_total,
  output logic [sactr_pkg::CNT_W-1:0]            miss_total,
  input  wire logic                              cfg_we,
  input  wire logic [sactr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sactr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [1:0]                   policy;
  logic                         alloc_on_write;
  logic                         clearing;
  logic                         req_valid, req_deq, req_alloc;
  logic [SB-1:0]                req_set;
  logic [TAG_BITS-1:0]          req_tag;
  logic [sactr_pkg::RAND_W-1:0] req_rand;
  logic                         res_push, res_space;
  sactr_pkg::res_t              res_q, res_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy         <= sactr_pkg::POL_LRU;
      alloc_on_write <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sactr_pkg::REG_POLICY: policy         <= cfg_data[1:0];
        sactr_pkg::REG_ALLOC:  alloc_on_write <= cfg_data[0];
      endcase
    end
  end

  sactr_front #(
    .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES), .CACHE_BYTES(CACHE_BYTES), .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .hold           (clearing),
    .push           (push),
    .full           (full),
    .addr           (addr),
    .is_write       (is_write),
    .rand_way       (rand_way),
    .alloc_on_write (alloc_on_write),
    .deq            (req_deq),
    .q_valid        (req_valid),
    .q_set          (req_set),
    .q_tag          (req_tag),
    .q_alloc        (req_alloc),
    .q_rand         (req_rand)
  );

  sactr_back #(
    .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES), .CACHE_BYTES(CACHE_BYTES), .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_set   (req_set),
    .req_tag   (req_tag),
    .req_alloc (req_alloc),
    .req_rand  (req_rand),
    .policy    (policy),
    .res_space (res_space),
    .req_deq   (req_deq),
    .clearing  (clearing),
    .res_push  (res_push),
    .res       (res_q)
  );

  sactr_res_fifo u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_q),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty),
    .space (res_space)
  );

  // Drive the result ports from the queue head
  assign hit        = res_head.hit;
  assign way_used   = res_head.way_used;
  assign allocated  = res_head.allocated;
  assign hit_total  = res_head.hit_total;
  assign miss_total = res_head.miss_total;

  // A result is only produced into a queue with room
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_space)
    else $error("result queue overflow");

  // A result is pushed in the cycle after its request is taken
  a_res_timing: assert property (@(posedge clk) disable iff (rst)
    res_push |-> $past(req_deq))
    else $error("result without a request one cycle earlier");

  // A hit never fills a line
  a_hit_no_fill: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_q.hit) |-> !res_q.allocated)
    else $error("hit reported as a fill");

endmodule

`default_nettype wire
